// ===== src/acat_pkg.sv =====
// Shared constants and types for the access counter aging table.
// No dependencies; used by the core and its bound checker.
package acat_pkg;

  localparam int unsigned Entries = 256;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned ActW    = IdxW + 1;
  localparam int unsigned CntW    = 8;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [CntW-1:0] MaxCountRst = CntW'(127);
  localparam logic [ActW-1:0] ActiveRst   = ActW'(Entries);
  localparam logic [ActW-1:0] EntriesAct  = ActW'(Entries);
  localparam logic [CntW-1:0] CntSat      = '1;

  // register indexes (paddr[2])
  localparam logic RegMaxCount = 1'b0;
  localparam logic RegActive   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_AGE  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            aged;
    logic            err;
  } result_t;

endpackage

// ===== src/access_counter_aging_table_core.sv =====
// Access counter table with aging by halving: one RAM, read-modify-write sequencer.
// Depends on acat_pkg.
//
//   channel  | handshake                        | payload
//   ---------+----------------------------------+-------------------------------------
//   in       | in_valid_i / in_stall_o          | entry_index_i
//   out      | out_valid_o / out_stall_i        | count_after_o, aged_o, index_error_o
//   config   | psel/penable/pwrite/pready       | paddr, pwdata, prdata
//
// An access reads the counter RAM, then updates the counter and writes it back.
// An access that ages the table adds a pass over the active entries, pipelined read and
// write on the single RAM.
// Reset clears all counters at once through per-entry valid bits; no clearing pass.
// A finished word sits in the output register; the next word is taken while it waits,
// and its result is held until the output register frees.
module access_counter_aging_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [acat_pkg::IdxW-1:0]    entry_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [acat_pkg::CntW-1:0]    count_after_o,
  output logic                         aged_o,
  output logic                         index_error_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [acat_pkg::AddrW-1:0]   paddr,
  input  logic [acat_pkg::DataW-1:0]   pwdata,
  output logic [acat_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  acat_pkg::state_e state_q, state_d;

  logic [acat_pkg::CntW-1:0] max_count_q;
  logic [acat_pkg::ActW-1:0] active_q;
  logic [acat_pkg::ActW-1:0] n_eff;

  logic [acat_pkg::CntW-1:0] mem [acat_pkg::Entries];
  logic [acat_pkg::Entries-1:0] vld_q;
  logic [acat_pkg::CntW-1:0] rdata_q;
  logic                      rd_vld_q;

  logic                      rd_en;
  logic [acat_pkg::IdxW-1:0] raddr;
  logic                      we;
  logic [acat_pkg::IdxW-1:0] waddr;
  logic [acat_pkg::CntW-1:0] wdata;

  logic [acat_pkg::IdxW-1:0] idx_q;
  logic                      err_q, err_d;
  logic [acat_pkg::ActW-1:0] age_rd_ptr_q, age_rd_ptr_d;
  logic                      age_wr_vld_q, age_wr_vld_d;
  logic [acat_pkg::IdxW-1:0] age_wr_ptr_q;

  acat_pkg::result_t res_q, res_d, mod_res, out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic                      in_acc;
  logic                      out_free;
  logic                      cfg_wr;
  logic [acat_pkg::CntW-1:0] cur_cnt;
  logic [acat_pkg::CntW-1:0] inc_cnt;
  logic                      mod_aging;
  logic [acat_pkg::CntW-1:0] aged_cnt;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign n_eff    = (active_q > acat_pkg::EntriesAct) ? acat_pkg::EntriesAct : active_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= acat_pkg::MaxCountRst;
      active_q    <= acat_pkg::ActiveRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        acat_pkg::RegMaxCount: max_count_q <= pwdata[acat_pkg::CntW-1:0];
        acat_pkg::RegActive:   active_q    <= pwdata[acat_pkg::ActW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      acat_pkg::RegMaxCount: prdata = acat_pkg::DataW'(max_count_q);
      acat_pkg::RegActive:   prdata = acat_pkg::DataW'(active_q);
      default:               prdata = '0;
    endcase
  end

  // counter RAM; a never-written entry reads as zero through its valid bit
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q  <= mem[raddr];
      rd_vld_q <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  assign cur_cnt   = rd_vld_q ? rdata_q : '0;
  assign inc_cnt   = (cur_cnt == acat_pkg::CntSat) ? cur_cnt : cur_cnt + 1'b1;
  assign mod_aging = !err_q && (inc_cnt >= max_count_q);
  assign aged_cnt  = cur_cnt >> 1;

  always_comb begin
    mod_res.count = err_q ? '0 : (mod_aging ? (inc_cnt >> 1) : inc_cnt);
    mod_res.aged  = mod_aging;
    mod_res.err   = err_q;
  end

  always_comb begin
    state_d      = state_q;
    err_d        = err_q;
    res_d        = res_q;
    out_d        = out_q;
    age_rd_ptr_d = age_rd_ptr_q;
    age_wr_vld_d = 1'b0;
    rd_en        = 1'b0;
    raddr        = age_rd_ptr_q[acat_pkg::IdxW-1:0];
    we           = 1'b0;
    waddr        = age_wr_ptr_q;
    wdata        = aged_cnt;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      acat_pkg::ST_IDLE: begin
        if (in_acc) begin
          rd_en   = 1'b1;
          raddr   = entry_index_i;
          err_d   = {1'b0, entry_index_i} >= n_eff;
          state_d = acat_pkg::ST_MOD;
        end
      end
      acat_pkg::ST_MOD: begin
        we    = !err_q;
        waddr = idx_q;
        wdata = inc_cnt;
        res_d = mod_res;
        if (mod_aging) begin
          age_rd_ptr_d = '0;
          state_d      = acat_pkg::ST_AGE;
        end else if (out_free) begin
          out_d       = mod_res;
          out_valid_d = 1'b1;
          state_d     = acat_pkg::ST_IDLE;
        end else begin
          state_d = acat_pkg::ST_DONE;
        end
      end
      acat_pkg::ST_AGE: begin
        // read entry p while writing back entry p-1 halved
        we = age_wr_vld_q;
        if (age_rd_ptr_q < n_eff) begin
          rd_en        = 1'b1;
          age_rd_ptr_d = age_rd_ptr_q + 1'b1;
          age_wr_vld_d = 1'b1;
        end else if (!age_wr_vld_q) begin
          state_d = acat_pkg::ST_DONE;
        end
      end
      acat_pkg::ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = acat_pkg::ST_IDLE;
        end
      end
      default: state_d = acat_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= acat_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      age_wr_vld_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      age_wr_vld_q <= age_wr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q <= entry_index_i;
    end
    err_q        <= err_d;
    res_q        <= res_d;
    out_q        <= out_d;
    age_rd_ptr_q <= age_rd_ptr_d;
    age_wr_ptr_q <= age_rd_ptr_q[acat_pkg::IdxW-1:0];
  end

  assign in_stall_o    = (state_q != acat_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign count_after_o = out_q.count;
  assign aged_o        = out_q.aged;
  assign index_error_o = out_q.err;

endmodule

// ===== src/acat_checker.sv =====
// Port-level checker for the access counter aging table, bound to the core.
// Depends on acat_pkg.
module acat_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [acat_pkg::CntW-1:0] count_after_o,
  input logic                      aged_o,
  input logic                      index_error_o
);

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_after_o)
      && $stable(aged_o) && $stable(index_error_o))
    else $error("result word changed while stalled");

  // one word at a time: busy in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on two consecutive cycles");

  // a rejected index reports nothing else
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> (count_after_o == '0) && !aged_o)
    else $error("index error with non-zero result fields");

  // a halved counter cannot exceed half the saturated value
  a_aged_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && aged_o |-> !count_after_o[acat_pkg::CntW-1] && !index_error_o)
    else $error("aged result out of range");

endmodule

bind access_counter_aging_table_core acat_checker u_acat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .count_after_o (count_after_o),
  .aged_o        (aged_o),
  .index_error_o (index_error_o)
);

// ===== test/testbench.sv =====
// Self-checking bench for access_counter_aging_table_core: directed words, then random phases.
// Depends on acat_pkg and the core; keeps its own mirror of the counter table for prediction.
`timescale 1ns / 1ps

module testbench;
  import acat_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int AgingPad   = 300;

  typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        sel;
    logic [31:0] wdata;
    logic [7:0]  idx;
    bit          typed;
    result_t     want;
  } plan_row_t;

  typedef struct {
    logic [7:0] max;
    logic [8:0] active;
    int         words;
    int         hot_pct;
    int         span;
  } phase_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [IdxW-1:0]       entry_index_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CntW-1:0]       count_after_o;
  logic                  aged_o;
  logic                  index_error_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AddrW-1:0]      paddr;
  logic [DataW-1:0]      pwdata;
  logic [DataW-1:0]      prdata;
  logic                  pready;

  logic [CntW-1:0] mirror_counts [Entries];
  logic [7:0]      cfg_max;
  logic [8:0]      cfg_active;
  result_t         due_results [$];
  plan_row_t       plan [$];
  phase_t          phases [7];
  int              mismatches;
  int              cycle_count;
  int              send_mode;
  int              stall_mode;
  int              hold_left;
  int              burst_left;

  access_counter_aging_table_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .entry_index_i (entry_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .count_after_o (count_after_o),
    .aged_o        (aged_o),
    .index_error_o (index_error_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Increment the named counter, age the active range when it hits the maximum.
  function automatic result_t predict_access(logic [7:0] idx);
    result_t r;
    int      n;
    int      c;
    n = (cfg_active > Entries) ? Entries : int'(cfg_active);
    r = '0;
    if (int'(idx) >= n) begin
      r.err = 1'b1;
      return r;
    end
    c = mirror_counts[idx];
    if (c < 255) c++;
    mirror_counts[idx] = CntW'(c);
    if (c >= int'(cfg_max)) begin
      r.aged = 1'b1;
      for (int i = 0; i < n; i++) mirror_counts[i] = mirror_counts[i] >> 1;
    end
    r.count = mirror_counts[idx];
    return r;
  endfunction

  function automatic void add_word(logic [7:0] idx);
    plan.push_back('{kind: ROW_WORD, sel: 1'b0, wdata: '0, idx: idx, typed: 1'b0,
                     want: '0});
  endfunction

  function automatic void add_checked(logic [7:0] idx, logic [7:0] cnt, logic aged,
                                      logic err);
    result_t w;
    w.count = cnt;
    w.aged  = aged;
    w.err   = err;
    plan.push_back('{kind: ROW_WORD, sel: 1'b0, wdata: '0, idx: idx, typed: 1'b1,
                     want: w});
  endfunction

  function automatic void add_write(logic sel, logic [31:0] val);
    plan.push_back('{kind: ROW_WRITE, sel: sel, wdata: val, idx: '0, typed: 1'b0,
                     want: '0});
  endfunction

  function automatic int pick_gap();
    int r;
    if (send_mode == 0) return 0;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one word; returns at the falling edge after it was taken.
  task automatic send_word(input logic [7:0] idx, input bit typed, input result_t typed_res);
    int      gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    entry_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_access(idx);
    due_results.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (due_results.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == RegMaxCount) cfg_max = val[7:0];
    else cfg_active = val[8:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver stall: quiet stretches, light noise, bursts, and the long hold-off on request.
  always @(negedge clk_i) begin
    int r;
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(2);
    r = $urandom_range(99);
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (burst_left > 0) begin
      out_stall_i <= 1'b1;
      burst_left  <= burst_left - 1;
    end else if (stall_mode == 0) begin
      out_stall_i <= 1'b0;
    end else if (stall_mode == 1) begin
      out_stall_i <= (r < 25);
    end else if (r < 5) begin
      out_stall_i <= 1'b1;
      burst_left  <= $urandom_range(10, 40);
    end else begin
      out_stall_i <= (r < 50);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected word count=%0d aged=%0d err=%0d", $realtime,
                 count_after_o, aged_o, index_error_o);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (count_after_o !== want.count) begin
          $display("%0t: count_after expected %0d got %0d", $realtime, want.count,
                   count_after_o);
          mismatches++;
        end
        if (aged_o !== want.aged) begin
          $display("%0t: aged expected %0d got %0d", $realtime, want.aged, aged_o);
          mismatches++;
        end
        if (index_error_o !== want.err) begin
          $display("%0t: index_error expected %0d got %0d", $realtime, want.err,
                   index_error_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("access_counter_aging_table_core test failed");
    $finish;
  end

  initial begin
    logic [7:0] hot [4];
    logic [7:0] idx;
    int         n;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    entry_index_i = '0;
    out_stall_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    send_mode     = 0;
    stall_mode    = 0;
    hold_left     = 0;
    burst_left    = 0;
    cfg_max       = MaxCountRst;
    cfg_active    = ActiveRst;
    foreach (mirror_counts[i]) mirror_counts[i] = '0;

    // after reset, then zero maximum, zero and oversized active range,
    // shrunk range keeping its counts, extreme indexes
    add_checked(8'd0,   8'd1, 1'b0, 1'b0);
    add_checked(8'd255, 8'd1, 1'b0, 1'b0);
    add_checked(8'd0,   8'd2, 1'b0, 1'b0);
    add_write(RegMaxCount, 32'd0);
    add_checked(8'd7,   8'd0, 1'b1, 1'b0);
    add_word(8'd0);
    add_write(RegActive, 32'd0);
    add_checked(8'd0,   8'd0, 1'b0, 1'b1);
    add_checked(8'd255, 8'd0, 1'b0, 1'b1);
    add_write(RegMaxCount, 32'd3);
    add_write(RegActive, 32'd300);
    add_word(8'd255);
    add_write(RegActive, 32'hFFFF_FE10);
    add_checked(8'd16,  8'd0, 1'b0, 1'b1);
    add_checked(8'd255, 8'd0, 1'b0, 1'b1);
    add_word(8'd15);
    add_word(8'd15);
    add_word(8'd15);
    add_write(RegActive, 32'd256);
    add_word(8'd255);
    add_write(RegMaxCount, 32'd255);
    add_word(8'd128);
    add_write(RegActive, 32'd511);
    add_word(8'hAA);
    add_word(8'h55);

    phases[0] = '{max: 8'd20,  active: 9'd256, words: 150, hot_pct: 70, span: 255};
    phases[1] = '{max: 8'd1,   active: 9'd32,  words: 60,  hot_pct: 0,  span: 40};
    phases[2] = '{max: 8'd255, active: 9'd1,   words: 300, hot_pct: 95, span: 255};
    phases[3] = '{max: 8'd0,   active: 9'd8,   words: 30,  hot_pct: 50, span: 15};
    phases[4] = '{max: 8'd64,  active: 9'd300, words: 150, hot_pct: 80, span: 255};
    phases[5] = '{max: 8'd5,   active: 9'd100, words: 100, hot_pct: 40, span: 130};
    phases[6] = '{max: 8'd127, active: 9'd511, words: 80,  hot_pct: 30, span: 255};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[k].sel, plan[k].wdata);
      end else begin
        send_word(plan[k].idx, plan[k].typed, plan[k].want);
      end
    end

    foreach (phases[p]) begin
      drain();
      write_reg(RegMaxCount, {24'd0, phases[p].max});
      write_reg(RegActive, {23'd0, phases[p].active});
      n = (cfg_active > Entries) ? Entries : int'(cfg_active);
      foreach (hot[h]) hot[h] = 8'($urandom_range(0, n - 1));
      for (int w = 0; w < phases[p].words; w++) begin
        if (w % 40 == 0) send_mode = $urandom_range(1);
        // long receiver hold-off while words keep coming: the block fills and stalls
        if (p == 0 && w == 50) hold_left = 400;
        // sender pause until everything outstanding is back
        if (p == 4 && w == 75) drain();
        if ($urandom_range(99) < phases[p].hot_pct) idx = hot[$urandom_range(3)];
        else idx = 8'($urandom_range(0, phases[p].span));
        send_word(idx, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    wait (due_results.size() == 0);
    repeat (AgingPad) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("access_counter_aging_table_core test passed");
    end else begin
      $display("access_counter_aging_table_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/acat_pkg.sv
src/access_counter_aging_table_core.sv
src/acat_checker.sv
test/testbench.sv
